// ===== hw/rtl/dtmu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtmu_pkg
// Shared widths, register map, reset values and helpers of the depth to mesh
// unprojector.
// ----------------------------------------------------------------------------
package dtmu_pkg;

	// default geometry
	localparam int DEF_SENSOR_WIDTH  = 640;
	localparam int DEF_SENSOR_HEIGHT = 480;
	localparam int DEF_MAX_STEP      = 8;

	// field widths
	localparam int DEPTH_W    = 16;
	localparam int POS_W      = 16;
	localparam int IDX_W      = 19;
	localparam int STEP_W     = 4;
	localparam int CLIP_W     = 16;
	localparam int PRINX_W    = 14;
	localparam int PRINY_W    = 13;
	localparam int GAIN_W     = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// gain is Q0.20 and the coordinate difference is in 1/16 pixel
	localparam int ROUND_SHIFT = 24;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_STEP        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAR_CLIP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_CULL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_X_GAIN      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN      = 3'd6;

	// register reset values
	localparam int                  RST_STEP        = 1;
	localparam logic [CLIP_W-1:0]   RST_FAR_CLIP    = 16'd6000;
	localparam logic [CLIP_W-1:0]   RST_EDGE_CULL   = 16'd4000;
	localparam logic [PRINX_W-1:0]  RST_PRINCIPAL_X = 14'd5120;
	localparam logic [PRINY_W-1:0]  RST_PRINCIPAL_Y = 13'd3840;
	localparam logic [GAIN_W-1:0]   RST_X_GAIN      = 20'd1855;
	localparam logic [GAIN_W-1:0]   RST_Y_GAIN      = 20'd1812;

	// result word kinds
	localparam logic KIND_VERTEX   = 1'b0;
	localparam logic KIND_TRIANGLE = 1'b1;

	// one row store entry
	typedef struct packed {
		logic               valid;
		logic [DEPTH_W-1:0] depth;
	} row_entry_t;

	// all corners valid and both first-corner depth differences under the cull
	function automatic logic tri_ok(
		input row_entry_t         a,
		input row_entry_t         b,
		input row_entry_t         c,
		input logic [CLIP_W-1:0]  cull
	);
		logic [DEPTH_W-1:0] dab;
		logic [DEPTH_W-1:0] dac;
		dab = (a.depth > b.depth) ? (a.depth - b.depth) : (b.depth - a.depth);
		dac = (a.depth > c.depth) ? (a.depth - c.depth) : (c.depth - a.depth);
		return a.valid && b.valid && c.valid && (dab < cull) && (dac < cull);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dtmu_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtmu_if
// Valid/ready channels of the depth to mesh unprojector: depth samples in,
// vertex and triangle words out, register writes.
// ----------------------------------------------------------------------------
interface dtmu_sample_if
	import dtmu_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [DEPTH_W-1:0] depth_sample;
	logic               frame_start;

	modport source (output valid, output depth_sample, output frame_start, input ready);
	modport sink   (input valid, input depth_sample, input frame_start, output ready);
endinterface

interface dtmu_result_if
	import dtmu_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic                     vertex_valid;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic [DEPTH_W-1:0]       pos_z;
	logic [IDX_W-1:0]         index_a;
	logic [IDX_W-1:0]         index_b;
	logic [IDX_W-1:0]         index_c;
	logic                     last;

	modport source (
		output valid, output kind, output vertex_valid, output pos_x, output pos_y,
		output pos_z, output index_a, output index_b, output index_c, output last,
		input ready
	);
	modport sink (
		input valid, input kind, input vertex_valid, input pos_x, input pos_y,
		input pos_z, input index_a, input index_b, input index_c, input last,
		output ready
	);
endinterface

interface dtmu_cfg_if
	import dtmu_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/dtmu_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtmu_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dtmu_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 640,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/dtmu_unproj.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtmu_unproj
// One axis of the pinhole unprojection: (16*coord - principal) * depth * gain,
// rounded half away from zero at 2^-24 and saturated to 16 bits signed.
// Two multiply stages (p1_s1, then p2_s2); pos is combinational from p2_s2.
// ----------------------------------------------------------------------------
module dtmu_unproj
	import dtmu_pkg::*;
#(
	parameter int COORD_W = 10,
	parameter int PRIN_W  = PRINX_W
) (
	input  logic                     clk,
	input  logic                     start,
	input  logic [COORD_W-1:0]       coord,
	input  logic [PRIN_W-1:0]        principal,
	input  logic [GAIN_W-1:0]        gain,
	input  logic [DEPTH_W-1:0]       depth,
	output logic signed [POS_W-1:0]  pos
);
	localparam int MAG_W = (COORD_W + 4 > PRIN_W) ? COORD_W + 4 : PRIN_W;
	localparam int P1_W  = MAG_W + DEPTH_W;
	localparam int P2_W  = P1_W + GAIN_W;
	localparam int Q_W   = P2_W + 1 - ROUND_SHIFT;

	localparam logic [POS_W:0] NEG_LIMIT = (POS_W + 1)'(1) << (POS_W - 1);
	localparam logic [POS_W:0] POS_LIMIT = NEG_LIMIT - (POS_W + 1)'(1);

	logic signed [MAG_W:0] diff;
	logic [MAG_W-1:0]      mag;
	logic                  neg;

	logic [P1_W-1:0]       p1_s1;
	logic                  neg_s1;
	logic [P2_W-1:0]       p2_s2;
	logic                  neg_s2;

	logic [P2_W:0]         rnd;
	logic [Q_W-1:0]        q;
	logic [POS_W:0]        lim;

	assign diff = $signed({1'b0, MAG_W'({coord, 4'b0000})})
		- $signed({1'b0, MAG_W'(principal)});
	assign neg  = diff[MAG_W];
	assign mag  = neg ? MAG_W'(-diff) : diff[MAG_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			p1_s1  <= P1_W'(mag) * P1_W'(depth);
			neg_s1 <= neg;
		end
		p2_s2  <= P2_W'(p1_s1) * P2_W'(gain);
		neg_s2 <= neg_s1;
	end

	// round half away from zero on the magnitude, then clamp per sign
	always_comb begin
		rnd = (P2_W + 1)'(p2_s2) + ((P2_W + 1)'(1) << (ROUND_SHIFT - 1));
		q   = rnd[P2_W:ROUND_SHIFT];
		if (neg_s2) begin
			lim = (q > Q_W'(NEG_LIMIT)) ? NEG_LIMIT : q[POS_W:0];
			pos = POS_W'((POS_W + 1)'(0) - lim);
		end else begin
			lim = (q > Q_W'(POS_LIMIT)) ? POS_LIMIT : q[POS_W:0];
			pos = lim[POS_W-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/depth_to_mesh_unprojector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// depth_to_mesh_unprojector
// Depth samples on a decimated grid in, one vertex word per sample plus up to
// two triangle words of full-resolution vertex indices out.
// ----------------------------------------------------------------------------
// Usage:
//   depth_in  carries one depth word per grid point in raster order;
//             frame_start restarts the grid at (0,0).
//   mesh_out  carries the vertex word, then the triangle words of the quad
//             closed by that point; last marks the final word of a sample.
//   cfg       writes registers; always ready, write only while idle.
//   A sample is read against the previous grid row kept in a row store RAM
//   (one read at accept, one write back when the results are known).
//   Each sample passes the states MUL, DONE and EMIT; in EMIT the vertex word,
//   then each triangle word, is loaded into the single word output register
//   when it is free. The two-stage multiply of the unprojection units runs
//   between accept and DONE.
//   Reset: registers take their defaults and the grid position is (0,0). The
//   row store needs no clearing: an entry is only used after the previous
//   grid row has written it. Writing step also restarts the grid.
//   A stalled receiver holds the output word; no new sample is taken until
//   every word of the current one has been loaded into the output register.
// ----------------------------------------------------------------------------
module depth_to_mesh_unprojector
	import dtmu_pkg::*;
#(
	parameter int SENSOR_WIDTH  = DEF_SENSOR_WIDTH,
	parameter int SENSOR_HEIGHT = DEF_SENSOR_HEIGHT,
	parameter int MAX_STEP      = DEF_MAX_STEP
) (
	input  logic          clk,
	input  logic          arst_n,
	dtmu_cfg_if.sink      cfg,
	dtmu_sample_if.sink   depth_in,
	dtmu_result_if.source mesh_out
);
	localparam int COL_W = $clog2(SENSOR_WIDTH);
	localparam int X_W   = $clog2(SENSOR_WIDTH + MAX_STEP);
	localparam int Y_W   = $clog2(SENSOR_HEIGHT + MAX_STEP);
	localparam int S_W   = $clog2(MAX_STEP + 1);
	localparam int ROW_W = $bits(row_entry_t);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam int PEND_VERT = 0;
	localparam int PEND_TRI1 = 1;
	localparam int PEND_TRI2 = 2;

	// configuration
	logic                cfg_wr;
	logic [S_W-1:0]      step_wr;
	logic [S_W-1:0]      step_q;
	logic [IDX_W-1:0]    step_row_q;
	logic [CLIP_W-1:0]   far_clip_q;
	logic [CLIP_W-1:0]   edge_cull_q;
	logic [PRINX_W-1:0]  principal_x_q;
	logic [PRINY_W-1:0]  principal_y_q;
	logic [GAIN_W-1:0]   x_gain_q;
	logic [GAIN_W-1:0]   y_gain_q;

	// grid position
	logic [COL_W-1:0]    col_q;
	logic [X_W-1:0]      x_q;
	logic [Y_W-1:0]      y_q;
	logic [IDX_W-1:0]    base_q;
	logic [IDX_W-1:0]    pbase_q;
	logic [COL_W-1:0]    col_e;
	logic [X_W-1:0]      x_e;
	logic [Y_W-1:0]      y_e;
	logic [IDX_W-1:0]    base_e;
	logic [X_W-1:0]      x_n;
	logic [Y_W-1:0]      y_n;

	// current sample
	logic [1:0]          state_q;
	logic                in_acc;
	logic [COL_W-1:0]    it_col_q;
	logic [X_W-1:0]      it_x_q;
	logic [Y_W-1:0]      it_y_q;
	logic [IDX_W-1:0]    it_base_q;
	logic [IDX_W-1:0]    it_ilr_q;
	logic [IDX_W-1:0]    it_iur_q;
	logic [DEPTH_W-1:0]  it_z_q;
	logic                it_valid_q;

	// neighbors
	row_entry_t          left_q;
	row_entry_t          ul_q;
	row_entry_t          up;
	row_entry_t          cur;
	logic [ROW_W-1:0]    ram_rdata;
	logic                cap;
	logic                quad;

	logic signed [POS_W-1:0] ux;
	logic signed [POS_W-1:0] uy;

	// results of the sample
	logic [2:0]              pend_q;
	logic [2:0]              pend_nxt;
	logic                    res_valid_q;
	logic signed [POS_W-1:0] res_pos_x_q;
	logic signed [POS_W-1:0] res_pos_y_q;
	logic [DEPTH_W-1:0]      res_pos_z_q;
	logic [IDX_W-1:0]        res_ill_q;
	logic [IDX_W-1:0]        res_iul_q;

	// output word
	logic                    slot_free;
	logic                    emit;
	logic                    e_kind;
	logic                    e_vvalid;
	logic signed [POS_W-1:0] e_px;
	logic signed [POS_W-1:0] e_py;
	logic [DEPTH_W-1:0]      e_pz;
	logic [IDX_W-1:0]        e_a;
	logic [IDX_W-1:0]        e_b;
	logic [IDX_W-1:0]        e_c;
	logic                    e_last;

	logic                    out_valid_q;
	logic                    out_kind_q;
	logic                    out_vvalid_q;
	logic signed [POS_W-1:0] out_pos_x_q;
	logic signed [POS_W-1:0] out_pos_y_q;
	logic [DEPTH_W-1:0]      out_pos_z_q;
	logic [IDX_W-1:0]        out_a_q;
	logic [IDX_W-1:0]        out_b_q;
	logic [IDX_W-1:0]        out_c_q;
	logic                    out_last_q;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid & cfg.ready;

	// clamp step to 1..MAX_STEP
	always_comb begin
		if (cfg.data[STEP_W-1:0] == '0) begin
			step_wr = S_W'(1);
		end else if (32'(cfg.data[STEP_W-1:0]) > 32'(MAX_STEP)) begin
			step_wr = S_W'(MAX_STEP);
		end else begin
			step_wr = S_W'(cfg.data[STEP_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= S_W'(RST_STEP);
			step_row_q    <= IDX_W'(RST_STEP * SENSOR_WIDTH);
			far_clip_q    <= RST_FAR_CLIP;
			edge_cull_q   <= RST_EDGE_CULL;
			principal_x_q <= RST_PRINCIPAL_X;
			principal_y_q <= RST_PRINCIPAL_Y;
			x_gain_q      <= RST_X_GAIN;
			y_gain_q      <= RST_Y_GAIN;
		end else if (cfg_wr) begin
			unique case (cfg.index)
				REG_STEP: begin
					step_q     <= step_wr;
					step_row_q <= IDX_W'(32'(step_wr) * SENSOR_WIDTH);
				end
				REG_FAR_CLIP:    far_clip_q    <= cfg.data[CLIP_W-1:0];
				REG_EDGE_CULL:   edge_cull_q   <= cfg.data[CLIP_W-1:0];
				REG_PRINCIPAL_X: principal_x_q <= cfg.data[PRINX_W-1:0];
				REG_PRINCIPAL_Y: principal_y_q <= cfg.data[PRINY_W-1:0];
				REG_X_GAIN:      x_gain_q      <= cfg.data[GAIN_W-1:0];
				REG_Y_GAIN:      y_gain_q      <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// accept and position
	// ------------------------------------------------------------------
	assign depth_in.ready = (state_q == ST_IDLE);
	assign in_acc         = depth_in.valid & depth_in.ready;

	// frame start restarts the grid before the word is handled
	always_comb begin
		col_e  = depth_in.frame_start ? '0 : col_q;
		x_e    = depth_in.frame_start ? '0 : x_q;
		y_e    = depth_in.frame_start ? '0 : y_q;
		base_e = depth_in.frame_start ? '0 : base_q;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			it_col_q   <= col_e;
			it_x_q     <= x_e;
			it_y_q     <= y_e;
			it_base_q  <= base_e;
			it_ilr_q   <= base_e + IDX_W'(x_e);
			it_iur_q   <= pbase_q + IDX_W'(x_e);
			it_z_q     <= depth_in.depth_sample;
			it_valid_q <= (depth_in.depth_sample != '0)
				&& (depth_in.depth_sample < far_clip_q);
		end
	end

	// ------------------------------------------------------------------
	// unprojection and row store
	// ------------------------------------------------------------------
	dtmu_unproj #(
		.COORD_W (X_W),
		.PRIN_W  (PRINX_W)
	) u_unproj_x (
		.clk       (clk),
		.start     (in_acc),
		.coord     (x_e),
		.principal (principal_x_q),
		.gain      (x_gain_q),
		.depth     (depth_in.depth_sample),
		.pos       (ux)
	);

	dtmu_unproj #(
		.COORD_W (Y_W),
		.PRIN_W  (PRINY_W)
	) u_unproj_y (
		.clk       (clk),
		.start     (in_acc),
		.coord     (y_e),
		.principal (principal_y_q),
		.gain      (y_gain_q),
		.depth     (depth_in.depth_sample),
		.pos       (uy)
	);

	assign cap = (state_q == ST_DONE);

	always_comb begin
		up        = row_entry_t'(ram_rdata);
		cur.valid = it_valid_q;
		cur.depth = it_valid_q ? it_z_q : '0;
		quad      = (it_col_q != '0) && (it_y_q != '0);
		x_n       = it_x_q + X_W'(step_q);
		y_n       = it_y_q + Y_W'(step_q);
	end

	dtmu_ram #(
		.WIDTH (ROW_W),
		.DEPTH (SENSOR_WIDTH)
	) u_row_store (
		.clk   (clk),
		.we    (cap),
		.waddr (it_col_q),
		.wdata (cur),
		.re    (in_acc),
		.raddr (col_e),
		.rdata (ram_rdata)
	);

	// capture neighbors and advance the grid once the sample is resolved; a step write restarts the grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			base_q  <= '0;
			pbase_q <= '0;
			left_q  <= '0;
			ul_q    <= '0;
		end else if (cfg_wr && cfg.index == REG_STEP) begin
			col_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			base_q  <= '0;
			pbase_q <= '0;
			left_q  <= '0;
			ul_q    <= '0;
		end else if (cap) begin
			left_q <= cur;
			ul_q   <= up;
			if (x_n >= X_W'(SENSOR_WIDTH)) begin
				col_q <= '0;
				x_q   <= '0;
				if (y_n >= Y_W'(SENSOR_HEIGHT)) begin
					y_q     <= '0;
					base_q  <= '0;
					pbase_q <= '0;
				end else begin
					y_q     <= y_n;
					base_q  <= it_base_q + step_row_q;
					pbase_q <= it_base_q;
				end
			end else begin
				col_q  <= it_col_q + COL_W'(1);
				x_q    <= x_n;
				y_q    <= it_y_q;
				base_q <= it_base_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			res_valid_q <= it_valid_q;
			res_pos_x_q <= it_valid_q ? ux : '0;
			res_pos_y_q <= it_valid_q ? uy : '0;
			res_pos_z_q <= cur.depth;
			res_ill_q   <= it_ilr_q - IDX_W'(step_q);
			res_iul_q   <= it_iur_q - IDX_W'(step_q);
		end
	end

	// ------------------------------------------------------------------
	// sequencer and output register
	// ------------------------------------------------------------------
	assign slot_free = !out_valid_q || mesh_out.ready;
	assign emit      = (state_q == ST_EMIT) && slot_free;

	// vertex first, then the upper-left triangle, then the lower-right one
	always_comb begin
		pend_nxt = pend_q;
		e_kind   = KIND_TRIANGLE;
		e_vvalid = 1'b0;
		e_px     = '0;
		e_py     = '0;
		e_pz     = '0;
		e_a      = it_iur_q;
		e_b      = res_ill_q;
		e_c      = it_ilr_q;
		priority if (pend_q[PEND_VERT]) begin
			pend_nxt[PEND_VERT] = 1'b0;
			e_kind   = KIND_VERTEX;
			e_vvalid = res_valid_q;
			e_px     = res_pos_x_q;
			e_py     = res_pos_y_q;
			e_pz     = res_pos_z_q;
			e_a      = it_ilr_q;
			e_b      = '0;
			e_c      = '0;
		end else if (pend_q[PEND_TRI1]) begin
			pend_nxt[PEND_TRI1] = 1'b0;
			e_a = res_iul_q;
			e_b = res_ill_q;
			e_c = it_iur_q;
		end else begin
			pend_nxt[PEND_TRI2] = 1'b0;
		end
		e_last = (pend_nxt == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					pend_q[PEND_VERT] <= 1'b1;
					pend_q[PEND_TRI1] <= quad && tri_ok(ul_q, left_q, up, edge_cull_q);
					pend_q[PEND_TRI2] <= quad && tri_ok(up, left_q, cur, edge_cull_q);
					state_q           <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						pend_q <= pend_nxt;
						if (pend_nxt == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (mesh_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q   <= e_kind;
			out_vvalid_q <= e_vvalid;
			out_pos_x_q  <= e_px;
			out_pos_y_q  <= e_py;
			out_pos_z_q  <= e_pz;
			out_a_q      <= e_a;
			out_b_q      <= e_b;
			out_c_q      <= e_c;
			out_last_q   <= e_last;
		end
	end

	assign mesh_out.valid        = out_valid_q;
	assign mesh_out.kind         = out_kind_q;
	assign mesh_out.vertex_valid = out_vvalid_q;
	assign mesh_out.pos_x        = out_pos_x_q;
	assign mesh_out.pos_y        = out_pos_y_q;
	assign mesh_out.pos_z        = out_pos_z_q;
	assign mesh_out.index_a      = out_a_q;
	assign mesh_out.index_b      = out_b_q;
	assign mesh_out.index_c      = out_c_q;
	assign mesh_out.last         = out_last_q;
endmodule
`default_nettype wire
